>>> rtl/rrt_pkg.sv
// Types and constants used by the range tracker core module.
// No dependencies.
package rrt_pkg;
    typedef enum logic [1:0] {
        REQ_MERGE  = 2'd0,
        REQ_REPORT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NO_GAP   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MREAD,
        S_MWALK,
        S_MCOPY,
        S_RREAD,
        S_RWALK,
        S_OUT
    } state_t;
endpackage

>>> rtl/rrt_if.sv
// Handshake channels of the range tracker: request, result and config write.
// Depends on nothing.
interface rrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] range_offset;
    logic [31:0] range_length;
    logic [4:0]  max_count;
    modport source (output valid, req_type, range_offset, range_length, max_count,
                    input ready);
    modport sink   (input valid, req_type, range_offset, range_length, max_count,
                    output ready);
endinterface

interface rrt_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] gap_offset;
    logic [31:0] gap_length;
    logic        is_complete;
    logic [4:0]  entries_used;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, gap_offset, gap_length, is_complete, entries_used,
                    status, last, input ready);
    modport sink   (input valid, gap_offset, gap_length, is_complete, entries_used,
                    status, last, output ready);
endinterface

interface rrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/received_range_tracker_core.sv
// Received range tracker top level: sorted range table in two memories.
// Depends on rrt_pkg and the channel interfaces in rrt_if.sv.
// A merge walks the table into scratch and, unless it overflows, copies scratch back into
// the table, then outputs its result; a report walks the table and emits its gaps.
// Items are handled one at a time. Reset (rst_n low, asynchronous) empties the table,
// clears completion and asset size; memories are not.
module received_range_tracker_core
    import rrt_pkg::*;
#(
    parameter int MAX_RANGES  = 16,
    parameter int OFFSET_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    rrt_req_if.sink   req,
    rrt_res_if.source res,
    rrt_cfg_if.sink   cfg
);
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 2);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int VW = OFFSET_BITS + 1;
    localparam logic [VW-1:0] LIM = {1'b1, {OFFSET_BITS{1'b0}}};

    // Table memories, old (A) and scratch (B); merge writes B then copies back
    logic [OFFSET_BITS-1:0] mem_first [MAX_RANGES];
    logic [OFFSET_BITS-1:0] mem_final [MAX_RANGES];
    logic [OFFSET_BITS-1:0] tmp_first [MAX_RANGES];
    logic [OFFSET_BITS-1:0] tmp_final [MAX_RANGES];

    state_t state_reg, state_next;
    logic [31:0] size_reg;
    logic [CW-1:0] count_reg, count_next;
    logic done_reg, done_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic placed_reg, placed_next;
    logic [VW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] low_reg, low_next;
    logic pend_reg, pend_next;
    logic [31:0] pg_off_reg, pg_off_next, pg_len_reg, pg_len_next;
    logic [1:0] stat_reg, stat_next;

    // Output register
    logic ov_reg, ov_next;
    logic [31:0] o_off_reg, o_off_next, o_len_reg, o_len_next;
    logic [1:0] o_st_reg, o_st_next;
    logic o_last_reg, o_last_next;
    logic o_done_reg, o_done_next;
    logic [4:0] o_cnt_reg, o_cnt_next;

    // Memory ports
    logic [AW-1:0] rd_addr;
    logic [OFFSET_BITS-1:0] rd_first, rd_final, tr_first, tr_final;
    logic t_we, a_we;
    logic [AW-1:0] t_addr;
    logic [OFFSET_BITS-1:0] t_wf, t_wl;

    logic [VW-1:0] span;
    assign span = ({1'b0, size_reg} > LIM) ? LIM : VW'({1'b0, size_reg});

    always_ff @(posedge clk)
    begin
        rd_first <= mem_first[rd_addr];
        rd_final <= mem_final[rd_addr];
        tr_first <= tmp_first[rd_addr];
        tr_final <= tmp_final[rd_addr];
        if (t_we)
        begin
            tmp_first[t_addr] <= t_wf;
            tmp_final[t_addr] <= t_wl;
        end
        if (a_we)
        begin
            mem_first[AW'(idx_reg)] <= tr_first;
            mem_final[AW'(idx_reg)] <= tr_final;
        end
    end

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= '0;
        else if (cfg.valid)
            size_reg <= cfg.data;
    end

    logic [VW-1:0] off_m, len_m, end_m, f_ext, l_ext;
    logic out_free;
    assign out_free = !ov_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign off_m = VW'(req.range_offset[OFFSET_BITS > 32 ? 31 : OFFSET_BITS-1:0]);
    assign len_m = VW'(req.range_length);
    assign f_ext = VW'(rd_first);
    assign l_ext = VW'(rd_final);

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg; count_next = count_reg; done_next = done_reg;
        idx_next = idx_reg; n_next = n_reg; placed_next = placed_reg;
        lo_next = lo_reg; hi_next = hi_reg; limit_next = limit_reg;
        cnt_next = cnt_reg; low_next = low_reg; pend_next = pend_reg;
        pg_off_next = pg_off_reg; pg_len_next = pg_len_reg;
        stat_next = stat_reg;
        ov_next = ov_reg && !res.ready;
        o_off_next = o_off_reg; o_len_next = o_len_reg; o_st_next = o_st_reg;
        o_last_next = o_last_reg; o_done_next = o_done_reg; o_cnt_next = o_cnt_reg;
        rd_addr = AW'(idx_reg); t_we = 1'b0; a_we = 1'b0;
        t_addr = AW'(n_reg); t_wf = '0; t_wl = '0;
        end_m = off_m + len_m - 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    idx_next = '0; n_next = '0; placed_next = 1'b0;
                    stat_next = ST_OK; low_next = '0; cnt_next = '0;
                    rd_addr = '0;
                    case (req_t'(req.req_type))
                        REQ_MERGE:
                        begin
                            lo_next = off_m;
                            hi_next = (end_m > span - 1'b1) ? span - 1'b1 : end_m;
                            if (req.range_length == '0 || off_m >= span)
                                state_next = S_OUT;
                            else
                                state_next = S_MREAD;
                        end
                        REQ_REPORT:
                        begin
                            limit_next = (LW'(req.max_count) > LW'(MAX_RANGES + 1)) ?
                                LW'(MAX_RANGES + 1) : LW'(req.max_count);
                            state_next = S_RREAD;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0; done_next = 1'b0; state_next = S_OUT;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_MREAD:
            begin
                // data for idx_reg arrives next cycle
                state_next = S_MWALK;
            end
            S_MWALK:
            begin
                if (idx_reg < count_reg)
                begin
                    if (l_ext + 1'b1 < lo_reg)
                    begin
                        t_we = 1'b1; t_wf = rd_first; t_wl = rd_final;
                        n_next = n_reg + 1'b1;
                    end
                    else if (f_ext > hi_reg + 1'b1)
                    begin
                        if (!placed_reg)
                        begin
                            t_we = 1'b1; t_wf = OFFSET_BITS'(lo_reg);
                            t_wl = OFFSET_BITS'(hi_reg);
                            placed_next = 1'b1; n_next = n_reg + 1'b1;
                            // revisit this entry next round
                            rd_addr = AW'(idx_reg);
                            state_next = S_MREAD;
                        end
                        else
                        begin
                            t_we = 1'b1; t_wf = rd_first; t_wl = rd_final;
                            n_next = n_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (f_ext < lo_reg) lo_next = f_ext;
                        if (l_ext > hi_reg) hi_next = l_ext;
                    end
                    if (n_next > CW'(MAX_RANGES) || (t_we && n_reg >= CW'(MAX_RANGES)))
                    begin
                        stat_next = ST_OVERFLOW; state_next = S_OUT; t_we = 1'b0;
                    end
                    else if (!(placed_next && !placed_reg))
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr = AW'(idx_reg + 1'b1);
                    end
                end
                else if (!placed_reg)
                begin
                    if (n_reg >= CW'(MAX_RANGES))
                    begin
                        stat_next = ST_OVERFLOW; state_next = S_OUT;
                    end
                    else
                    begin
                        t_we = 1'b1; t_wf = OFFSET_BITS'(lo_reg);
                        t_wl = OFFSET_BITS'(hi_reg);
                        n_next = n_reg + 1'b1; placed_next = 1'b1;
                    end
                end
                else
                begin
                    // commit: copy scratch back into the table
                    count_next = n_reg;
                    if (n_reg == CW'(1) && lo_reg == '0 && hi_reg == span - 1'b1)
                        done_next = 1'b1;
                    idx_next = '0; rd_addr = '0; state_next = S_MCOPY;
                end
            end
            S_MCOPY:
            begin
                // tr_* holds scratch entry idx_reg; write it into the table
                a_we = 1'b1;
                if (idx_reg == count_reg - 1'b1)
                    state_next = S_OUT;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr = AW'(idx_reg + 1'b1);
                end
            end
            S_RREAD:
            begin
                state_next = S_RWALK;
            end
            S_RWALK:
            begin
                if (out_free)
                begin
                    logic [VW-1:0] stop;
                    stop = (idx_reg < count_reg) ? f_ext : span;
                    if (stop > span) stop = span;
                    if (LW'(cnt_reg) >= limit_reg || idx_reg > count_reg)
                    begin
                        if (cnt_reg == '0)
                        begin
                            ov_next = 1'b1; o_off_next = '0; o_len_next = '0;
                            o_st_next = ST_NO_GAP; o_last_next = 1'b1;
                            o_done_next = done_reg; o_cnt_next = 5'(count_reg);
                        end
                        else if (pend_reg)
                        begin
                            // flush the held gap as the final item
                            ov_next = 1'b1; o_off_next = pg_off_reg;
                            o_len_next = pg_len_reg; o_st_next = ST_OK;
                            o_last_next = 1'b1; o_done_next = done_reg;
                            o_cnt_next = 5'(count_reg);
                        end
                        pend_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (low_reg < stop)
                        begin
                            // emit the held gap, hold the new one
                            if (pend_reg)
                            begin
                                ov_next = 1'b1; o_off_next = pg_off_reg;
                                o_len_next = pg_len_reg; o_st_next = ST_OK;
                                o_last_next = 1'b0; o_done_next = done_reg;
                                o_cnt_next = 5'(count_reg);
                            end
                            pend_next = 1'b1;
                            pg_off_next = 32'(low_reg);
                            pg_len_next = 32'(stop - low_reg);
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (idx_reg < count_reg)
                            low_next = l_ext + 1'b1;
                        idx_next = idx_reg + 1'b1;
                        rd_addr = AW'(idx_reg + 1'b1);
                        state_next = S_RREAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; o_off_next = '0; o_len_next = '0;
                    o_st_next = stat_next; o_last_next = 1'b1;
                    o_done_next = done_reg; o_cnt_next = 5'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; count_reg <= '0; done_reg <= 1'b0;
            ov_reg <= 1'b0; pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; count_reg <= count_next; done_reg <= done_next;
            ov_reg <= ov_next; pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; n_reg <= n_next; placed_reg <= placed_next;
        lo_reg <= lo_next; hi_reg <= hi_next; limit_reg <= limit_next;
        cnt_reg <= cnt_next; low_reg <= low_next; stat_reg <= stat_next;
        pg_off_reg <= pg_off_next; pg_len_reg <= pg_len_next;
        o_off_reg <= o_off_next; o_len_reg <= o_len_next; o_st_reg <= o_st_next;
        o_last_reg <= o_last_next; o_done_reg <= o_done_next; o_cnt_reg <= o_cnt_next;
    end

    assign res.valid = ov_reg;
    assign res.gap_offset = o_off_reg;
    assign res.gap_length = o_len_reg;
    assign res.status = o_st_reg;
    assign res.last = o_last_reg;
    assign res.is_complete = o_done_reg;
    assign res.entries_used = o_cnt_reg;

    // Table never exceeds its capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES)) else $error("table count overflow");
    // Requests are only taken while idle
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> state_reg == S_IDLE) else $error("busy accept");
    // Clear empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.req_type == REQ_CLEAR |=> count_reg == '0)
        else $error("clear failed");
endmodule
